[rtl/fbpa_pkg.sv]
// Shared constants and types for the fixed block pool allocator.
// Used by the link memory, the block count divider and the top level.
`default_nettype none

package fbpa_pkg;

    // Pool geometry
    localparam int POOL_BYTES      = 4096;
    localparam int MIN_BLOCK_BYTES = 16;
    localparam int MAX_BLOCKS      = 256;

    // Field widths
    localparam int IDX_W  = 8;
    localparam int CNT_W  = 9;
    localparam int SIZE_W = 13;
    localparam int OFF_W  = 12;

    // Block count divider: one quotient bit per cycle over the pool size
    localparam int DIV_STEPS = SIZE_W;
    localparam int DIV_CNT_W = 4;

    localparam logic [SIZE_W-1:0] POOL_DIVIDEND = SIZE_W'(POOL_BYTES);
    localparam logic [SIZE_W-1:0] MIN_SIZE      = SIZE_W'(MIN_BLOCK_BYTES);
    localparam logic [CNT_W-1:0]  EMPTY_HEAD    = CNT_W'(MAX_BLOCKS);
    localparam logic [CNT_W-1:0]  RESET_BLOCKS  = CNT_W'(POOL_BYTES / MIN_BLOCK_BYTES);

    // Operation codes carried in s_tuser
    typedef enum logic {
        FUNC_ALLOC = 1'b0,
        FUNC_FREE  = 1'b1
    } func_t;

    // Request to the link memory
    typedef struct packed {
        logic             we;
        logic [IDX_W-1:0] waddr;
        logic [IDX_W-1:0] wdata;
        logic             re;
        logic [IDX_W-1:0] raddr;
    } link_req_t;

    // Divider status
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

`default_nettype wire

[rtl/fbpa_link_ram.sv]
// Link memory of the free-block stack: 256 x 8, one write and one read port,
// registered read data. Depends on fbpa_pkg.
`default_nettype none

module fbpa_link_ram (
    input  wire logic                      aclk,
    input  wire fbpa_pkg::link_req_t       req,
    output logic [fbpa_pkg::IDX_W-1:0]     rdata
);
    import fbpa_pkg::*;

    logic [IDX_W-1:0] mem [MAX_BLOCKS];
    logic [IDX_W-1:0] rdata_reg;

    // Write port
    always_ff @(posedge aclk) begin
        if (req.we) begin
            mem[req.waddr] <= req.wdata;
        end
    end

    // Read port, registered read data
    always_ff @(posedge aclk) begin
        if (req.re) begin
            rdata_reg <= mem[req.raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

[rtl/fbpa_div.sv]
// Restoring divider for the block count: pool bytes over block size,
// one quotient bit per cycle. Depends on fbpa_pkg.
`default_nettype none

module fbpa_div (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        start,
    input  wire logic [fbpa_pkg::SIZE_W-1:0] divisor,
    output fbpa_pkg::div_stat_t              stat,
    output logic [fbpa_pkg::CNT_W-1:0]       quotient
);
    import fbpa_pkg::*;

    logic [SIZE_W-1:0]    div_reg;
    logic [SIZE_W-1:0]    rem_reg, rem_next;
    logic [SIZE_W-1:0]    q_reg, q_next;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 busy_reg, done_reg;
    logic [SIZE_W:0]      trial;
    logic                 ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits
    always_comb begin
        trial    = {rem_reg, POOL_DIVIDEND[cnt_reg]};
        ge       = (trial >= {1'b0, div_reg});
        rem_next = ge ? SIZE_W'(trial - {1'b0, div_reg}) : trial[SIZE_W-1:0];
        q_next   = {q_reg[SIZE_W-2:0], ge};
    end

    // Step control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (busy_reg) begin
                if (cnt_reg == '0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg - 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            div_reg <= divisor;
            rem_reg <= '0;
            q_reg   <= '0;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

    // Cap at the reach of an 8-bit index
    assign quotient  = (q_reg > SIZE_W'(MAX_BLOCKS)) ? EMPTY_HEAD : q_reg[CNT_W-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

`default_nettype wire

[rtl/fixed_block_pool_allocator_top.sv]
// Top level of the fixed block pool allocator: stream ports, stack control,
// result register. Depends on fbpa_pkg, fbpa_link_ram and fbpa_div.
//
// Fixed-size block allocator over a 4096-byte pool. A beat on s_ with
// s_tuser = 0 allocates a block, s_tuser = 1 frees the block in s_tdata.
// Every input beat gives one result beat: ok in m_tuser, then index, byte
// offset and blocks left in m_tdata. Freed blocks are reused last-in first
// out through a 256 x 8 link memory; untouched blocks go out in ascending
// order. Frees, failed allocates, allocates of untouched blocks and
// allocates that take the last block off the freed stack stay in
// ST_IDLE; an allocate that leaves blocks on the freed stack passes
// through ST_POP, since the link of the head block comes out of the
// synchronous link memory in the cycle after the read. A write of the
// block size on cfg_ reinitializes the pool and runs the block count
// divider, during which no input beat is taken. A result waiting in the
// result register holds off the next input beat until m_tready takes it.
`default_nettype none

module fixed_block_pool_allocator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input: tuser = func; tdata = block_index[7:0]
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic        s_tuser,
    input  wire logic [7:0]  s_tdata,
    // Result: tuser = ok; tdata = given_index[7:0], given_offset[19:8],
    // free_left[28:20], zero[31:29]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic             m_tuser,
    output logic [31:0]      m_tdata,
    // Configuration: tdata = bytes per block[12:0], upper bits ignored
    input  wire logic        cfg_tvalid,
    output logic             cfg_tready,
    input  wire logic [15:0] cfg_tdata
);
    import fbpa_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_POP,
        ST_INIT
    } state_t;

    state_t            state_reg;
    logic [CNT_W-1:0]  head_reg;
    logic [CNT_W-1:0]  untouched_reg;
    logic [CNT_W-1:0]  free_reg;
    logic [CNT_W-1:0]  blocks_reg;
    logic [SIZE_W-1:0] size_reg;

    logic              m_valid_reg;
    logic              m_ok_reg;
    logic [IDX_W-1:0]  m_idx_reg;
    logic [OFF_W-1:0]  m_off_reg;
    logic [CNT_W-1:0]  m_left_reg;

    link_req_t         link_req;
    logic [IDX_W-1:0]  link_rdata;
    div_stat_t         div_stat;
    logic [CNT_W-1:0]  div_quot;

    logic              s_accept, cfg_accept;
    func_t             func;
    logic [CNT_W-1:0]  depth;
    logic              from_stack, last_on_stack;
    logic              alloc_ok, free_ok;
    logic [IDX_W-1:0]  alloc_idx;
    logic [OFF_W-1:0]  alloc_off;
    logic [SIZE_W-1:0] cfg_size;

    // Handshakes
    assign cfg_tready = (state_reg == ST_IDLE);
    assign s_tready   = (state_reg == ST_IDLE) && !cfg_tvalid && (!m_valid_reg || m_tready);
    assign s_accept   = s_tvalid && s_tready;
    assign cfg_accept = cfg_tvalid && cfg_tready;
    assign func       = func_t'(s_tuser);

    // Decide the operation from the current stack state
    always_comb begin
        depth         = free_reg - (blocks_reg - untouched_reg);
        from_stack    = (depth != '0) && (head_reg != EMPTY_HEAD);
        last_on_stack = (depth == CNT_W'(1));
        alloc_ok      = (free_reg != '0);
        alloc_idx     = from_stack ? head_reg[IDX_W-1:0] : untouched_reg[IDX_W-1:0];
        alloc_off     = OFF_W'(alloc_idx) * size_reg[OFF_W-1:0];
        free_ok       = ({1'b0, s_tdata} < blocks_reg) && (free_reg < blocks_reg);
        cfg_size      = (cfg_tdata[SIZE_W-1:0] < MIN_SIZE) ? MIN_SIZE
                                                           : cfg_tdata[SIZE_W-1:0];
    end

    // Link memory access: push writes the old head, pop reads the next one
    always_comb begin
        link_req.we    = s_accept && (func == FUNC_FREE) && free_ok;
        link_req.waddr = s_tdata;
        link_req.wdata = (head_reg != EMPTY_HEAD) ? head_reg[IDX_W-1:0] : '0;
        link_req.re    = s_accept && (func == FUNC_ALLOC) && alloc_ok
                         && from_stack && !last_on_stack;
        link_req.raddr = head_reg[IDX_W-1:0];
    end

    fbpa_link_ram u_link_ram (
        .aclk  (aclk),
        .req   (link_req),
        .rdata (link_rdata)
    );

    fbpa_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cfg_accept),
        .divisor  (cfg_size),
        .stat     (div_stat),
        .quotient (div_quot)
    );

    // State, pool counters and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            head_reg      <= EMPTY_HEAD;
            untouched_reg <= '0;
            free_reg      <= RESET_BLOCKS;
            blocks_reg    <= RESET_BLOCKS;
            size_reg      <= MIN_SIZE;
            m_valid_reg   <= 1'b0;
        end else begin
            // Drop the result once taken, load a new one on accept
            if (s_accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (cfg_accept) begin
                        size_reg  <= cfg_size;
                        state_reg <= ST_INIT;
                    end else if (s_accept) begin
                        if (func == FUNC_ALLOC) begin
                            if (alloc_ok) begin
                                free_reg <= free_reg - 1'b1;
                                if (from_stack) begin
                                    if (last_on_stack) begin
                                        head_reg <= EMPTY_HEAD;
                                    end else begin
                                        state_reg <= ST_POP;
                                    end
                                end else begin
                                    untouched_reg <= untouched_reg + 1'b1;
                                end
                            end
                        end else if (free_ok) begin
                            head_reg <= {1'b0, s_tdata};
                            free_reg <= free_reg + 1'b1;
                        end
                    end
                end
                ST_POP: begin
                    // Advance the head to the link read out of memory
                    head_reg  <= {1'b0, link_rdata};
                    state_reg <= ST_IDLE;
                end
                ST_INIT: begin
                    if (div_stat.done) begin
                        blocks_reg    <= div_quot;
                        free_reg      <= div_quot;
                        untouched_reg <= '0;
                        head_reg      <= EMPTY_HEAD;
                        state_reg     <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Result payload
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            if (func == FUNC_ALLOC) begin
                m_ok_reg   <= alloc_ok;
                m_idx_reg  <= alloc_ok ? alloc_idx : '0;
                m_off_reg  <= alloc_ok ? alloc_off : '0;
                m_left_reg <= alloc_ok ? free_reg - 1'b1 : free_reg;
            end else begin
                m_ok_reg   <= free_ok;
                m_idx_reg  <= '0;
                m_off_reg  <= '0;
                m_left_reg <= free_ok ? free_reg + 1'b1 : free_reg;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_ok_reg;
    assign m_tdata  = {3'b000, m_left_reg, m_off_reg, m_idx_reg};

endmodule

`default_nettype wire

[rtl/fbpa_checker.sv]
// Port-level checks for the fixed block pool allocator, bound to the top.
// Depends on fixed_block_pool_allocator_top.
`default_nettype none

module fbpa_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_tvalid,
    input wire logic        s_tready,
    input wire logic        m_tvalid,
    input wire logic        m_tready,
    input wire logic        m_tuser,
    input wire logic [31:0] m_tdata,
    input wire logic        cfg_tvalid,
    input wire logic        cfg_tready
);

    // A stalled result beat holds its payload
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Every accepted input beat shows a result in the next cycle
    a_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted beat gave no result");

    // A failed operation reports no block
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> m_tdata[19:0] == 20'd0)
        else $error("failed result carries a block");

    // Free count never exceeds the block limit
    a_left_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[28:20] <= 9'd256 && m_tdata[31:29] == 3'd0)
        else $error("free count out of range");

    // Reinitialization holds off input beats
    a_cfg_block: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_tvalid && cfg_tready |=> !s_tready)
        else $error("input taken during reinitialization");

endmodule

bind fixed_block_pool_allocator_top fbpa_checker u_fbpa_checker (.*);

`default_nettype wire
